### rtl/core/ihex_pkg.sv
// Shared types, codes and the hex digit decoder for the Intel HEX record parser.
package ihex_pkg;

    localparam int ADDR_W  = 17;
    localparam int BASE_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int PHASE_W = 3;
    localparam int CFG_INDEX_W = 1;

    localparam logic [KIND_W-1:0] KIND_CHAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SOF  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EOF  = 2'd2;

    localparam logic [KIND_W-1:0] RES_WRITE  = 2'd0;
    localparam logic [KIND_W-1:0] RES_RECORD = 2'd1;
    localparam logic [KIND_W-1:0] RES_FILE   = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_LOW_SEED  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_HIGH_SEED = 1'b1;

    localparam logic [PHASE_W-1:0] PH_SEEK = 3'd0;
    localparam logic [PHASE_W-1:0] PH_LEN  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_ADDR = 3'd2;
    localparam logic [PHASE_W-1:0] PH_TYPE = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DATA = 3'd4;
    localparam logic [PHASE_W-1:0] PH_CKS  = 3'd5;

    localparam logic [BYTE_W-1:0] COLON_CHAR = 8'h3A;
    localparam logic [ADDR_W-1:0] LOW_RESET  = 17'd65790;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              is_colon;
        logic              is_hex;
        logic [3:0]        nibble;
    } ihex_item_t;

    // {valid, nibble}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [7:0] t;
        logic [4:0] r;
        t = 8'h00;
        r = 5'h00;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            t = c - 8'h30;
            r = {1'b1, t[3:0]};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            t = c - 8'h37;
            r = {1'b1, t[3:0]};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            t = c - 8'h57;
            r = {1'b1, t[3:0]};
        end
        return r;
    endfunction

endpackage

### rtl/core/ihex_front.sv
// Front end: takes input beats and classifies each character for the queue.
module ihex_front
    import ihex_pkg::*;
(
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [KIND_W-1:0] kind,
    input  logic [7:0]        char_code,
    input  logic              full,
    output logic              push,
    output ihex_item_t        push_item
);

    logic [4:0] dec;

    assign dec      = hex_decode(char_code);
    assign in_stall = full;
    assign push     = in_valid && !full;

    always_comb
    begin
        push_item.kind     = kind;
        push_item.is_colon = (char_code == COLON_CHAR);
        push_item.is_hex   = dec[4];
        push_item.nibble   = dec[3:0];
    end

endmodule

### rtl/core/ihex_queue.sv
// Short queue of classified beats between the front end and the record sequencer.
module ihex_queue
    import ihex_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  ihex_item_t push_item,
    output logic       full,
    input  logic       pop,
    output logic       pop_valid,
    output ihex_item_t pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    ihex_item_t       store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == DEPTH_CNT);
    assign pop_valid = (count_reg != '0);
    assign pop_item  = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("queue count out of range");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("pop from empty queue");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

endmodule

### rtl/core/ihex_back.sv
// Record sequencer: field assembly, record state, bounds and the result register.
module ihex_back
    import ihex_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop_valid,
    input  ihex_item_t        pop_item,
    output logic              pop,
    input  logic [ADDR_W-1:0] low_seed,
    input  logic [ADDR_W-1:0] high_seed,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [KIND_W-1:0] result_kind,
    output logic [ADDR_W-1:0] write_address,
    output logic [BYTE_W-1:0] write_data,
    output logic [BASE_W-1:0] record_base,
    output logic [ADDR_W-1:0] record_end,
    output logic              checksum_error,
    output logic [ADDR_W-1:0] low_bound,
    output logic [ADDR_W-1:0] high_bound
);

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [1:0]         digit_count_reg, digit_count_next;
    logic [BASE_W-1:0]  field_value_reg, field_value_next;
    logic               field_stopped_reg, field_stopped_next;
    logic [BYTE_W-1:0]  record_length_reg, record_length_next;
    logic [BYTE_W-1:0]  bytes_done_reg, bytes_done_next;
    logic [BASE_W-1:0]  base_address_reg, base_address_next;
    logic [ADDR_W-1:0]  next_address_reg, next_address_next;
    logic [BYTE_W-1:0]  byte_sum_reg, byte_sum_next;
    logic [ADDR_W-1:0]  low_seen_reg, low_seen_next;
    logic [ADDR_W-1:0]  high_seen_reg, high_seen_next;

    logic               out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]  rkind_reg, rkind_next;
    logic [ADDR_W-1:0]  waddr_reg, waddr_next;
    logic [BYTE_W-1:0]  wdata_reg, wdata_next;
    logic [BASE_W-1:0]  rbase_reg, rbase_next;
    logic [ADDR_W-1:0]  rend_reg, rend_next;
    logic               cerr_reg, cerr_next;
    logic [ADDR_W-1:0]  lbound_reg, lbound_next;
    logic [ADDR_W-1:0]  hbound_reg, hbound_next;

    logic               take;
    logic               emit;
    logic [BASE_W-1:0]  acc;
    logic               stop_new;
    logic               last_digit;
    logic [BYTE_W-1:0]  sum_cks;
    logic [BYTE_W-1:0]  bd_inc;
    logic [ADDR_W-1:0]  low_upd;
    logic [ADDR_W-1:0]  high_upd;

    assign take = pop_valid && (!out_valid_reg || !out_stall);
    assign pop  = take;

    assign acc        = (!field_stopped_reg && pop_item.is_hex) ?
                        {field_value_reg[11:0], pop_item.nibble} : field_value_reg;
    assign stop_new   = field_stopped_reg || !pop_item.is_hex;
    assign last_digit = (phase_reg == PH_ADDR) ? (digit_count_reg == 2'd3)
                                               : (digit_count_reg == 2'd1);
    assign sum_cks    = byte_sum_reg + acc[7:0];
    assign bd_inc     = bytes_done_reg + 1'b1;
    assign low_upd    = (low_seen_reg > {1'b0, base_address_reg}) ?
                        {1'b0, base_address_reg} : low_seen_reg;
    assign high_upd   = (high_seen_reg < next_address_reg) ? next_address_reg
                                                           : high_seen_reg;

    always_comb
    begin
        phase_next         = phase_reg;
        digit_count_next   = digit_count_reg;
        field_value_next   = field_value_reg;
        field_stopped_next = field_stopped_reg;
        record_length_next = record_length_reg;
        bytes_done_next    = bytes_done_reg;
        base_address_next  = base_address_reg;
        next_address_next  = next_address_reg;
        byte_sum_next      = byte_sum_reg;
        low_seen_next      = low_seen_reg;
        high_seen_next     = high_seen_reg;
        emit        = 1'b0;
        rkind_next  = RES_WRITE;
        waddr_next  = '0;
        wdata_next  = '0;
        rbase_next  = '0;
        rend_next   = '0;
        cerr_next   = 1'b0;
        lbound_next = '0;
        hbound_next = '0;

        if (take)
        begin
            case (pop_item.kind)
                KIND_SOF:
                begin
                    phase_next         = PH_SEEK;
                    digit_count_next   = '0;
                    field_value_next   = '0;
                    field_stopped_next = 1'b0;
                    record_length_next = '0;
                    bytes_done_next    = '0;
                    base_address_next  = '0;
                    next_address_next  = '0;
                    byte_sum_next      = '0;
                    low_seen_next      = low_seed;
                    high_seen_next     = high_seed;
                end
                KIND_EOF:
                begin
                    phase_next         = PH_SEEK;
                    digit_count_next   = '0;
                    field_value_next   = '0;
                    field_stopped_next = 1'b0;
                    record_length_next = '0;
                    bytes_done_next    = '0;
                    base_address_next  = '0;
                    next_address_next  = '0;
                    byte_sum_next      = '0;
                    emit        = 1'b1;
                    rkind_next  = RES_FILE;
                    lbound_next = low_seen_reg;
                    hbound_next = high_seen_reg;
                end
                KIND_CHAR:
                begin
                    if (phase_reg == PH_SEEK || phase_reg > PH_CKS)
                    begin
                        phase_next         = (phase_reg == PH_SEEK && pop_item.is_colon) ?
                                             PH_LEN : PH_SEEK;
                        if (phase_reg != PH_SEEK || pop_item.is_colon)
                        begin
                            digit_count_next   = '0;
                            field_value_next   = '0;
                            field_stopped_next = 1'b0;
                            record_length_next = '0;
                            bytes_done_next    = '0;
                            base_address_next  = '0;
                            next_address_next  = '0;
                            byte_sum_next      = '0;
                        end
                    end
                    else if (!last_digit)
                    begin
                        digit_count_next   = digit_count_reg + 1'b1;
                        field_value_next   = acc;
                        field_stopped_next = stop_new;
                    end
                    else
                    begin
                        digit_count_next   = '0;
                        field_value_next   = '0;
                        field_stopped_next = 1'b0;
                        case (phase_reg)
                            PH_LEN:
                            begin
                                record_length_next = acc[7:0];
                                byte_sum_next      = byte_sum_reg + acc[7:0];
                                phase_next         = PH_ADDR;
                            end
                            PH_ADDR:
                            begin
                                base_address_next = acc;
                                next_address_next = {1'b0, acc};
                                byte_sum_next     = byte_sum_reg + acc[15:8] + acc[7:0];
                                phase_next        = PH_TYPE;
                            end
                            PH_TYPE:
                            begin
                                byte_sum_next = byte_sum_reg + acc[7:0];
                                if (acc != '0)
                                begin
                                    phase_next = PH_SEEK;
                                end
                                else
                                begin
                                    bytes_done_next = '0;
                                    phase_next = (record_length_reg != '0) ? PH_DATA : PH_CKS;
                                end
                            end
                            PH_DATA:
                            begin
                                emit              = 1'b1;
                                rkind_next        = RES_WRITE;
                                waddr_next        = next_address_reg;
                                wdata_next        = acc[7:0];
                                next_address_next = next_address_reg + 1'b1;
                                byte_sum_next     = byte_sum_reg + acc[7:0];
                                bytes_done_next   = bd_inc;
                                if (bd_inc == record_length_reg)
                                begin
                                    phase_next = PH_CKS;
                                end
                            end
                            default:
                            begin
                                byte_sum_next  = sum_cks;
                                low_seen_next  = low_upd;
                                high_seen_next = high_upd;
                                emit        = 1'b1;
                                rkind_next  = RES_RECORD;
                                rbase_next  = base_address_reg;
                                rend_next   = next_address_reg;
                                cerr_next   = (sum_cks != '0);
                                lbound_next = low_upd;
                                hbound_next = high_upd;
                                phase_next  = PH_SEEK;
                            end
                        endcase
                    end
                end
                default:
                begin
                end
            endcase
        end

        out_valid_next = take ? emit : (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_SEEK;
            digit_count_reg   <= '0;
            field_value_reg   <= '0;
            field_stopped_reg <= 1'b0;
            record_length_reg <= '0;
            bytes_done_reg    <= '0;
            base_address_reg  <= '0;
            next_address_reg  <= '0;
            byte_sum_reg      <= '0;
            low_seen_reg      <= LOW_RESET;
            high_seen_reg     <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            phase_reg         <= phase_next;
            digit_count_reg   <= digit_count_next;
            field_value_reg   <= field_value_next;
            field_stopped_reg <= field_stopped_next;
            record_length_reg <= record_length_next;
            bytes_done_reg    <= bytes_done_next;
            base_address_reg  <= base_address_next;
            next_address_reg  <= next_address_next;
            byte_sum_reg      <= byte_sum_next;
            low_seen_reg      <= low_seen_next;
            high_seen_reg     <= high_seen_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            rkind_reg  <= rkind_next;
            waddr_reg  <= waddr_next;
            wdata_reg  <= wdata_next;
            rbase_reg  <= rbase_next;
            rend_reg   <= rend_next;
            cerr_reg   <= cerr_next;
            lbound_reg <= lbound_next;
            hbound_reg <= hbound_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_kind    = rkind_reg;
    assign write_address  = waddr_reg;
    assign write_data     = wdata_reg;
    assign record_base    = rbase_reg;
    assign record_end     = rend_reg;
    assign checksum_error = cerr_reg;
    assign low_bound      = lbound_reg;
    assign high_bound     = hbound_reg;

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= PH_CKS)
        else $error("phase out of range");

    a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> bytes_done_reg < record_length_reg)
        else $error("data byte count overran record length");

    a_digit_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_ADDR |-> digit_count_reg <= 2'd1)
        else $error("digit count exceeds field length");

endmodule

### rtl/core/intel_hex_record_parser.sv
// Top level of the Intel HEX record parser: seed registers and the front/queue/back chain.
// Takes one beat per clock, sustained, with no gaps between records or files: each
// character goes through a combinational classifier into a QUEUE_DEPTH-entry queue, and the
// record sequencer retires one queued beat per clock, while the result side is not stalled,
// into a single result register. Input stalls only when the queue is full, which happens
// only after the result side has stalled. Write the seed registers between files; a
// start-of-file beat loads them into the running bounds.
module intel_hex_record_parser
    import ihex_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [KIND_W-1:0]      kind,
    input  logic [7:0]             char_code,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]      cfg_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [KIND_W-1:0]      result_kind,
    output logic [ADDR_W-1:0]      write_address,
    output logic [BYTE_W-1:0]      write_data,
    output logic [BASE_W-1:0]      record_base,
    output logic [ADDR_W-1:0]      record_end,
    output logic                   checksum_error,
    output logic [ADDR_W-1:0]      low_bound,
    output logic [ADDR_W-1:0]      high_bound
);

    logic [ADDR_W-1:0] low_seed_reg;
    logic [ADDR_W-1:0] high_seed_reg;
    logic              q_full;
    logic              q_push;
    ihex_item_t        q_push_item;
    logic              q_pop;
    logic              q_pop_valid;
    ihex_item_t        q_pop_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_seed_reg  <= LOW_RESET;
            high_seed_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_LOW_SEED:  low_seed_reg  <= cfg_data;
                REG_HIGH_SEED: high_seed_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    ihex_front u_front (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .char_code (char_code),
        .full      (q_full),
        .push      (q_push),
        .push_item (q_push_item)
    );

    ihex_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_pop_valid),
        .pop_item  (q_pop_item)
    );

    ihex_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .pop_valid      (q_pop_valid),
        .pop_item       (q_pop_item),
        .pop            (q_pop),
        .low_seed       (low_seed_reg),
        .high_seed      (high_seed_reg),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_kind    (result_kind),
        .write_address  (write_address),
        .write_data     (write_data),
        .record_base    (record_base),
        .record_end     (record_end),
        .checksum_error (checksum_error),
        .low_bound      (low_bound),
        .high_bound     (high_bound)
    );

endmodule

### bench/testbench.sv
// Self-checking testbench for intel_hex_record_parser: directed rows, then random HEX files.
module testbench;
    import ihex_pkg::*;

    localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
    localparam int ITEM_TARGET    = 1550;
    localparam int CALM_TAIL      = 250;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DIR_ROWS       = 27;

    typedef struct packed {
        logic [KIND_W-1:0] rk;
        logic [ADDR_W-1:0] wa;
        logic [BYTE_W-1:0] wd;
        logic [BASE_W-1:0] rb;
        logic [ADDR_W-1:0] re;
        logic              ce;
        logic [ADDR_W-1:0] lb;
        logic [ADDR_W-1:0] hb;
    } hex_result_t;

    typedef struct packed {
        logic [KIND_W-1:0] k;
        logic [7:0]        c;
        logic              typed;
        hex_result_t       res;
    } dir_row_t;

    localparam hex_result_t NO_RES = '0;
    localparam hex_result_t FILE_AFTER_RESET =
        '{RES_FILE, 17'd0, 8'd0, 16'd0, 17'd0, 1'b0, LOW_RESET, 17'd0};
    localparam hex_result_t WRITE_TOP =
        '{RES_WRITE, 17'h0FFFF, 8'hFF, 16'd0, 17'd0, 1'b0, 17'd0, 17'd0};
    localparam hex_result_t REC_TOP_BAD_SUM =
        '{RES_RECORD, 17'd0, 8'd0, 16'hFFFF, 17'h10000, 1'b1, 17'h0FFFF, 17'h10000};
    localparam hex_result_t REC_EMPTY =
        '{RES_RECORD, 17'd0, 8'd0, 16'h0000, 17'd0, 1'b0, 17'd0, 17'h10000};

    // EOF right after reset, ignored kind, top-address record with bad sum,
    // zero-length record whose length field stops early, then start of file.
    dir_row_t dir_table [DIR_ROWS] = '{
        '{KIND_EOF,  8'h00, 1'b1, FILE_AFTER_RESET},
        '{KIND_NONE, ":",   1'b0, NO_RES},
        '{KIND_CHAR, ":",   1'b0, NO_RES},
        '{KIND_CHAR, "0",   1'b0, NO_RES},
        '{KIND_CHAR, "1",   1'b0, NO_RES},
        '{KIND_CHAR, "f",   1'b0, NO_RES},
        '{KIND_CHAR, "f",   1'b0, NO_RES},
        '{KIND_CHAR, "F",   1'b0, NO_RES},
        '{KIND_CHAR, "F",   1'b0, NO_RES},
        '{KIND_CHAR, "0",   1'b0, NO_RES},
        '{KIND_CHAR, "0",   1'b0, NO_RES},
        '{KIND_CHAR, "F",   1'b0, NO_RES},
        '{KIND_CHAR, "F",   1'b1, WRITE_TOP},
        '{KIND_CHAR, "0",   1'b0, NO_RES},
        '{KIND_CHAR, "3",   1'b1, REC_TOP_BAD_SUM},
        '{KIND_CHAR, ":",   1'b0, NO_RES},
        '{KIND_CHAR, "0",   1'b0, NO_RES},
        '{KIND_CHAR, 8'hFF, 1'b0, NO_RES},
        '{KIND_CHAR, "0",   1'b0, NO_RES},
        '{KIND_CHAR, "0",   1'b0, NO_RES},
        '{KIND_CHAR, "0",   1'b0, NO_RES},
        '{KIND_CHAR, "0",   1'b0, NO_RES},
        '{KIND_CHAR, "0",   1'b0, NO_RES},
        '{KIND_CHAR, "0",   1'b0, NO_RES},
        '{KIND_CHAR, "0",   1'b0, NO_RES},
        '{KIND_CHAR, "0",   1'b1, REC_EMPTY},
        '{KIND_SOF,  8'hFF, 1'b0, NO_RES}
    };

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [KIND_W-1:0]      kind = KIND_CHAR;
    logic [7:0]             char_code = 8'h00;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_LOW_SEED;
    logic [ADDR_W-1:0]      cfg_data = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [KIND_W-1:0]      result_kind;
    logic [ADDR_W-1:0]      write_address;
    logic [BYTE_W-1:0]      write_data;
    logic [BASE_W-1:0]      record_base;
    logic [ADDR_W-1:0]      record_end;
    logic                   checksum_error;
    logic [ADDR_W-1:0]      low_bound;
    logic [ADDR_W-1:0]      high_bound;

    // parser model state
    logic [PHASE_W-1:0] ph = PH_SEEK;
    logic [1:0]         dig_cnt = '0;
    logic [15:0]        fval = '0;
    logic               fstop = 1'b0;
    logic [7:0]         rec_len = '0;
    logic [7:0]         nbytes = '0;
    logic [BASE_W-1:0]  base = '0;
    logic [ADDR_W-1:0]  next_addr = '0;
    logic [7:0]         csum = '0;
    logic [ADDR_W-1:0]  lo_seen = LOW_RESET;
    logic [ADDR_W-1:0]  hi_seen = '0;
    logic [ADDR_W-1:0]  seed_lo = LOW_RESET;
    logic [ADDR_W-1:0]  seed_hi = '0;

    hex_result_t pending_results [$];
    logic [7:0]  rec_text [$];
    logic        typed_hit = 1'b0;
    hex_result_t typed_res = '0;
    logic        idle_on = 1'b1;
    int          beats_sent = 0;
    int          fail_count = 0;
    int          shown_count = 0;
    int          stall_left = 0;
    int          quiet_cycles = 0;

    intel_hex_record_parser i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .char_code      (char_code),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_kind    (result_kind),
        .write_address  (write_address),
        .write_data     (write_data),
        .record_base    (record_base),
        .record_end     (record_end),
        .checksum_error (checksum_error),
        .low_bound      (low_bound),
        .high_bound     (high_bound)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void clear_record();
        ph = PH_SEEK;
        dig_cnt = '0;
        fval = '0;
        fstop = 1'b0;
        rec_len = '0;
        nbytes = '0;
        base = '0;
        next_addr = '0;
        csum = '0;
    endfunction

    function automatic logic predict_beat(input logic [KIND_W-1:0] k, input logic [7:0] c,
                                          output hex_result_t r);
        logic [7:0]  t;
        logic [3:0]  nib;
        logic        is_hex;
        logic [1:0]  last_digit;
        logic [15:0] v;
        r = '0;
        nib = '0;
        t = '0;
        if (k == KIND_SOF)
        begin
            clear_record();
            lo_seen = seed_lo;
            hi_seen = seed_hi;
            return 1'b0;
        end
        if (k == KIND_EOF)
        begin
            clear_record();
            r.rk = RES_FILE;
            r.lb = lo_seen;
            r.hb = hi_seen;
            return 1'b1;
        end
        if (k != KIND_CHAR)
            return 1'b0;
        if (ph == PH_SEEK)
        begin
            if (c == COLON_CHAR)
            begin
                clear_record();
                ph = PH_LEN;
            end
            return 1'b0;
        end

        is_hex = 1'b1;
        if (c >= "0" && c <= "9")
            t = c - 8'h30;
        else if (c >= "A" && c <= "F")
            t = c - 8'h37;
        else if (c >= "a" && c <= "f")
            t = c - 8'h57;
        else
            is_hex = 1'b0;
        nib = t[3:0];
        if (!fstop && is_hex)
            fval = {fval[11:0], nib};
        else
            fstop = 1'b1;

        last_digit = (ph == PH_ADDR) ? 2'd3 : 2'd1;
        if (dig_cnt != last_digit)
        begin
            dig_cnt = dig_cnt + 2'd1;
            return 1'b0;
        end
        v = fval;
        dig_cnt = '0;
        fval = '0;
        fstop = 1'b0;

        case (ph)
            PH_LEN:
            begin
                rec_len = v[7:0];
                csum = csum + v[7:0];
                ph = PH_ADDR;
            end
            PH_ADDR:
            begin
                base = v;
                next_addr = {1'b0, v};
                csum = csum + v[15:8] + v[7:0];
                ph = PH_TYPE;
            end
            PH_TYPE:
            begin
                csum = csum + v[7:0];
                if (v != 16'd0)
                    ph = PH_SEEK;
                else
                begin
                    nbytes = '0;
                    ph = (rec_len != 8'd0) ? PH_DATA : PH_CKS;
                end
            end
            PH_DATA:
            begin
                r.rk = RES_WRITE;
                r.wa = next_addr;
                r.wd = v[7:0];
                next_addr = next_addr + 17'd1;
                csum = csum + v[7:0];
                nbytes = nbytes + 8'd1;
                if (nbytes == rec_len)
                    ph = PH_CKS;
                return 1'b1;
            end
            default:
            begin
                csum = csum + v[7:0];
                if (lo_seen > {1'b0, base})
                    lo_seen = {1'b0, base};
                if (hi_seen < next_addr)
                    hi_seen = next_addr;
                r.rk = RES_RECORD;
                r.rb = base;
                r.re = next_addr;
                r.ce = (csum != 8'd0);
                r.lb = lo_seen;
                r.hb = hi_seen;
                ph = PH_SEEK;
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    function automatic string show(input hex_result_t x);
        return $sformatf("kind=%0d addr=%h data=%h base=%h end=%h cerr=%b low=%h high=%h",
                         x.rk, x.wa, x.wd, x.rb, x.re, x.ce, x.lb, x.hb);
    endfunction

    function automatic void report_mismatch(input string what, input hex_result_t want,
                                            input hex_result_t got);
        fail_count++;
        if (shown_count < 10)
        begin
            shown_count++;
            $display("%s\n  expected: %s\n  actual:   %s", what, show(want), show(got));
        end
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return 8'h30 + {4'd0, n};
        if ($urandom_range(0, 1) == 0)
            return 8'h37 + {4'd0, n};
        return 8'h57 + {4'd0, n};
    endfunction

    function automatic void put_byte(input logic [7:0] b);
        rec_text.push_back(hex_char(b[7:4]));
        rec_text.push_back(hex_char(b[3:0]));
    endfunction

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_beat(input logic [KIND_W-1:0] k, input logic [7:0] c);
        hex_result_t r;
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        char_code <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (predict_beat(k, c, r))
        begin
            if (typed_hit)
                r = typed_res;
            pending_results.push_back(r);
        end
        typed_hit = 1'b0;
        if (k != KIND_NONE)
            beats_sent++;
        @(negedge clk);
    endtask

    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_seeds(input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] hi);
        cfg_valid <= 1'b1;
        cfg_index <= REG_LOW_SEED;
        cfg_data <= lo;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        seed_lo = lo;
        @(negedge clk);
        cfg_index <= REG_HIGH_SEED;
        cfg_data <= hi;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        seed_hi = hi;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_record(input logic [7:0] len, input logic [15:0] addr,
                               input logic [7:0] rtype);
        logic [7:0] sum;
        logic [7:0] b;
        int         i;
        int         cut;
        rec_text.delete();
        rec_text.push_back(COLON_CHAR);
        put_byte(len);
        put_byte(addr[15:8]);
        put_byte(addr[7:0]);
        put_byte(rtype);
        sum = len + addr[15:8] + addr[7:0] + rtype;
        for (i = 0; i < int'(len); i++)
        begin
            b = 8'($urandom);
            sum = sum + b;
            put_byte(b);
        end
        if ($urandom_range(0, 4) == 0)
            put_byte(8'($urandom));
        else
            put_byte(8'h00 - sum);
        // damaged record: random bytes land inside fields
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 2))
                rec_text[$urandom_range(1, rec_text.size() - 1)] = 8'($urandom);
        cut = rec_text.size();
        if ($urandom_range(0, 19) == 0)
            cut = $urandom_range(1, rec_text.size() - 1);
        for (i = 0; i < cut; i++)
        begin
            if ($urandom_range(0, 99) == 0)
                send_beat(KIND_NONE, 8'($urandom));
            send_beat(KIND_CHAR, rec_text[i]);
        end
        if (cut < rec_text.size())
            send_beat(KIND_EOF, 8'($urandom));
        if ($urandom_range(0, 1) == 0)
        begin
            send_beat(KIND_CHAR, 8'h0D);
            send_beat(KIND_CHAR, 8'h0A);
        end
        repeat ($urandom_range(0, 2)) send_beat(KIND_CHAR, 8'($urandom));
    endtask

    always @(negedge clk)
    begin
        if (stall_left > 0)
            stall_left = stall_left - 1;
        else if (idle_on && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 4);
        out_stall <= idle_on && stall_left > 0;
    end

    always @(posedge clk)
    begin
        hex_result_t got;
        hex_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {result_kind, write_address, write_data, record_base, record_end,
                   checksum_error, low_bound, high_bound};
            if (pending_results.size() == 0)
                report_mismatch("result with none expected", NO_RES, got);
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                    report_mismatch("result mismatch", want, got);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int          i;
        int          phase_no;
        logic [7:0]  len;
        logic [7:0]  rtype;
        logic [15:0] addr;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < DIR_ROWS; i++)
        begin
            typed_hit = dir_table[i].typed;
            typed_res = dir_table[i].res;
            send_beat(dir_table[i].k, dir_table[i].c);
        end

        phase_no = 0;
        while (beats_sent < ITEM_TARGET)
        begin
            idle_on = (beats_sent < ITEM_TARGET - CALM_TAIL) && ($urandom_range(0, 4) != 0);
            drain_pipeline();
            case (phase_no)
                0: write_seeds(17'd0, LOW_RESET);
                1: write_seeds(LOW_RESET, 17'd0);
                2: write_seeds(LOW_RESET, LOW_RESET);
                default: write_seeds(17'($urandom_range(0, 65790)),
                                     17'($urandom_range(0, 65790)));
            endcase
            send_beat(KIND_SOF, 8'($urandom));
            if (phase_no == 3)
                send_record(8'hFF, 16'hFFFF, 8'h00);
            repeat ($urandom_range(2, 8))
            begin
                if ($urandom_range(0, 19) < 14)
                    len = 8'($urandom_range(0, 6));
                else
                    len = 8'($urandom_range(7, 40));
                addr = 16'($urandom);
                if ($urandom_range(0, 3) == 0)
                    addr[15:8] = 8'hFF;
                rtype = 8'h00;
                if ($urandom_range(0, 6) == 0)
                    rtype = 8'($urandom_range(1, 255));
                send_record(len, addr, rtype);
            end
            send_beat(KIND_EOF, 8'($urandom));
            phase_no++;
        end

        idle_on = 1'b0;
        drain_pipeline();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
